>>> design/triangle_tangent_generator_defines.svh
// ----------------------------------------------------------------------------
// triangle tangent generator assertion macros
// property checks used by the top level; empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_GENERATOR_DEFINES_SVH
`define TRIANGLE_TANGENT_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define TTG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ttg assertion failed");

`define TTG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ttg assertion failed");

`else

`define TTG_ASSERT_IMP(lbl, ante, cons)

`define TTG_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> design/ttg_pkg.sv
// ----------------------------------------------------------------------------
// ttg_pkg
// shared types, constants and the multiply step table of the tangent generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttg_pkg;

    localparam int COORD_WIDTH_DEF = 32;

    localparam int ED_W     = 34;
    localparam int OP_W     = 33;
    localparam int ACC_W    = 64;
    localparam int ACC_N    = 14;
    localparam int SQ_W     = 44;
    localparam int SQ_ITERS = 22;
    localparam int LEN_W    = 22;
    localparam int MAG_W    = 21;
    localparam int UNIT_SH  = 14;
    localparam int NUM_W    = MAG_W + UNIT_SH;
    localparam int Q_W      = 16;
    localparam int TAN_W    = 16;
    localparam int TB_SPLIT = 21;
    localparam int FIT_K_IN = 30;
    localparam int FIT_K_VEC = 20;

    localparam logic [Q_W-1:0] UNIT_Q = Q_W'(1 << UNIT_SH);

    localparam logic [4:0] SRC_E    = 5'd0;
    localparam logic [4:0] SRC_D    = 5'd6;
    localparam logic [4:0] SRC_NA   = 5'd10;
    localparam logic [4:0] SRC_NB   = 5'd13;
    localparam logic [4:0] SRC_T    = 5'd16;
    localparam logic [4:0] SRC_B    = 5'd19;
    localparam logic [4:0] SRC_N    = 5'd22;
    localparam logic [4:0] SRC_TBLO = 5'd25;
    localparam logic [4:0] SRC_TBHI = 5'd28;

    localparam logic [3:0] ACC_T   = 4'd0;
    localparam logic [3:0] ACC_B   = 4'd3;
    localparam logic [3:0] ACC_N0  = 4'd6;
    localparam logic [3:0] ACC_TB  = 4'd9;
    localparam logic [3:0] ACC_DOT = 4'd12;
    localparam logic [3:0] ACC_S   = 4'd13;

    localparam logic [5:0] STEP_T   = 6'd0;
    localparam logic [5:0] STEP_B   = 6'd6;
    localparam logic [5:0] STEP_N   = 6'd12;
    localparam logic [5:0] STEP_TB  = 6'd18;
    localparam logic [5:0] STEP_DOT = 6'd24;
    localparam logic [5:0] STEP_S   = 6'd30;
    localparam logic [5:0] STEP_END = 6'd33;

    typedef struct packed {
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic       neg;
        logic       first;
        logic       sh;
        logic [3:0] dst;
    } t_mstep;

    typedef struct packed {
        logic       load_slot_en;
        logic       load_slot;
        logic       load_tri;
        logic       fit_ed;
        logic       fit_tbn;
        logic       mul_issue;
        logic [5:0] step;
        logic       sq_init;
        logic       sq_step;
        logic       dv_init;
        logic       dv_step;
        logic       dv_store;
        logic [1:0] comp;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic ed_done;
        logic tbn_done;
    } t_stat;

    function automatic logic mag_ge(input logic signed [ACC_W-1:0] v, input int unsigned k);
        logic signed [ACC_W-1:0] lim;
        lim = ACC_W'(64'sd1 <<< k);
        return (v >= lim) || (v <= -lim);
    endfunction

    function automatic logic [1:0] rot3(input logic [1:0] i, input logic [1:0] k);
        logic [2:0] s;
        s = {1'b0, i} + {1'b0, k};
        if (s >= 3'd3) begin
            s = s - 3'd3;
        end
        return s[1:0];
    endfunction

    function automatic t_mstep step_cmd(input logic [5:0] idx);
        t_mstep     m;
        logic [5:0] j;
        logic [1:0] i;
        logic       sec;
        logic [1:0] ia;
        logic [1:0] ib;
        m   = '0;
        j   = 6'd0;
        if (idx < STEP_B) begin
            j = idx - STEP_T;
        end else if (idx < STEP_N) begin
            j = idx - STEP_B;
        end else if (idx < STEP_TB) begin
            j = idx - STEP_N;
        end else if (idx < STEP_DOT) begin
            j = idx - STEP_TB;
        end else if (idx < STEP_S) begin
            j = idx - STEP_DOT;
        end else begin
            j = idx - STEP_S;
        end
        i   = j[2:1];
        sec = j[0];
        ia  = rot3(i, sec ? 2'd2 : 2'd1);
        ib  = rot3(i, sec ? 2'd1 : 2'd2);
        m.neg   = sec;
        m.first = !sec;
        if (idx < STEP_B) begin
            m.src_a = sec ? SRC_E + 5'd3 + {3'b0, i} : SRC_E + {3'b0, i};
            m.src_b = sec ? SRC_D + 5'd2 : SRC_D + 5'd3;
            m.dst   = ACC_T + {2'b0, i};
        end else if (idx < STEP_N) begin
            m.src_a = sec ? SRC_E + 5'd3 + {3'b0, i} : SRC_E + {3'b0, i};
            m.src_b = sec ? SRC_D : SRC_D + 5'd1;
            m.dst   = ACC_B + {2'b0, i};
        end else if (idx < STEP_TB) begin
            m.src_a = SRC_NA + {3'b0, ia};
            m.src_b = SRC_NB + {3'b0, ib};
            m.dst   = ACC_N0 + {2'b0, i};
        end else if (idx < STEP_DOT) begin
            m.src_a = SRC_T + {3'b0, ia};
            m.src_b = SRC_B + {3'b0, ib};
            m.dst   = ACC_TB + {2'b0, i};
        end else if (idx < STEP_S) begin
            m.src_a = sec ? SRC_TBLO + {3'b0, i} : SRC_TBHI + {3'b0, i};
            m.src_b = SRC_N + {3'b0, i};
            m.neg   = 1'b0;
            m.sh    = !sec;
            m.first = !sec && (i == 2'd0);
            m.dst   = ACC_DOT;
        end else begin
            m.src_a = SRC_T + {3'b0, j[1:0]};
            m.src_b = SRC_T + {3'b0, j[1:0]};
            m.neg   = 1'b0;
            m.first = (j[1:0] == 2'd0);
            m.dst   = ACC_S;
        end
        return m;
    endfunction

endpackage

>>> design/triangle_tangent_generator.sv
// ----------------------------------------------------------------------------
// triangle_tangent_generator
// per-triangle unit tangent and handedness from a stream of vertex words
//
//   channel   handshake            payload
//   vertex    i_valid / o_ready    i_pos_x/y/z, i_tex_u/v, i_mesh_start
//   tangent   o_valid / i_ready    o_tangent_x/y/z, o_mirrored
//
// first and second vertex of a triangle: held only, o_ready stays high
// third vertex: o_ready stays low until the result is loaded; the busy time is set by
//   one-bit-a-cycle block scaling (up to 29 and 42 steps), 33 passes through the
//   single shared multiplier, a 22-step square root and three 16-step divisions
// reset clears the sequencer, vertex grouping, result valid and multiplier write-back flag only
// a waiting result sits in the output register; the next triangle is still taken and
//   computed, and waits to load while the register is still occupied
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triangle_tangent_generator_defines.svh"

module triangle_tangent_generator #(
    parameter int COORD_WIDTH = ttg_pkg::COORD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_tex_u,
    input  logic signed [31:0] i_tex_v,
    input  logic               i_mesh_start,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_tangent_x,
    output logic signed [15:0] o_tangent_y,
    output logic signed [15:0] o_tangent_z,
    output logic               o_mirrored
);

    ttg_pkg::t_cmd  w_cmd;
    ttg_pkg::t_stat w_stat;

    ttg_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_mesh_start (i_mesh_start),
        .o_ready      (o_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd)
    );

    ttg_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_tex_u     (i_tex_u),
        .i_tex_v     (i_tex_v),
        .o_tangent_x (o_tangent_x),
        .o_tangent_y (o_tangent_y),
        .o_tangent_z (o_tangent_z),
        .o_mirrored  (o_mirrored)
    );

    `TTG_ASSERT_NEXT(a_busy_after_tri, i_valid && o_ready && w_cmd.load_tri, !o_ready)
    `TTG_ASSERT_NEXT(a_load_sets_valid, w_cmd.load_out, o_valid)
    `TTG_ASSERT_IMP(a_no_overwrite, w_cmd.load_out, !o_valid || i_ready)
    `TTG_ASSERT_IMP(a_mul_not_idle, w_cmd.mul_issue, !o_ready)

endmodule

>>> design/ttg_ctrl.sv
// ----------------------------------------------------------------------------
// ttg_ctrl
// vertex grouping and the sequencer that steps the datapath through a triangle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_mesh_start,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  ttg_pkg::t_stat i_stat,
    output ttg_pkg::t_cmd  o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_FIT_ED    = 13'b0000000000010,
        S_MUL_A     = 13'b0000000000100,
        S_FLUSH_A   = 13'b0000000001000,
        S_FIT_TBN   = 13'b0000000010000,
        S_MUL_B     = 13'b0000000100000,
        S_FLUSH_B   = 13'b0000001000000,
        S_SQ_INIT   = 13'b0000010000000,
        S_SQRT      = 13'b0000100000000,
        S_DIV_INIT  = 13'b0001000000000,
        S_DIV       = 13'b0010000000000,
        S_DIV_STORE = 13'b0100000000000,
        S_LOAD      = 13'b1000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic [1:0] r_comp, n_comp;
    logic [1:0] r_phase, n_phase;
    logic       r_ovalid, n_ovalid;
    logic [1:0] w_ph;

    assign w_ph    = (i_mesh_start || (r_phase == 2'd3)) ? 2'd0 : r_phase;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_comp   = r_comp;
        n_phase  = r_phase;
        n_ovalid = r_ovalid && !i_ready;
        o_cmd      = '0;
        o_cmd.step = r_cnt;
        o_cmd.comp = r_comp;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (w_ph != 2'd2) begin
                        o_cmd.load_slot_en = 1'b1;
                        o_cmd.load_slot    = w_ph[0];
                        n_phase            = w_ph + 2'd1;
                    end else begin
                        o_cmd.load_tri = 1'b1;
                        n_phase        = 2'd0;
                        n_state        = S_FIT_ED;
                    end
                end
            end
            S_FIT_ED: begin
                o_cmd.fit_ed = 1'b1;
                if (i_stat.ed_done) begin
                    n_cnt   = ttg_pkg::STEP_T;
                    n_state = S_MUL_A;
                end
            end
            S_MUL_A: begin
                o_cmd.mul_issue = 1'b1;
                n_cnt           = r_cnt + 6'd1;
                if (r_cnt == ttg_pkg::STEP_TB - 6'd1) begin
                    n_state = S_FLUSH_A;
                end
            end
            S_FLUSH_A: begin
                n_state = S_FIT_TBN;
            end
            S_FIT_TBN: begin
                o_cmd.fit_tbn = 1'b1;
                if (i_stat.tbn_done) begin
                    n_cnt   = ttg_pkg::STEP_TB;
                    n_state = S_MUL_B;
                end
            end
            S_MUL_B: begin
                o_cmd.mul_issue = 1'b1;
                n_cnt           = r_cnt + 6'd1;
                if (r_cnt == ttg_pkg::STEP_END - 6'd1) begin
                    n_state = S_FLUSH_B;
                end
            end
            S_FLUSH_B: begin
                n_state = S_SQ_INIT;
            end
            S_SQ_INIT: begin
                o_cmd.sq_init = 1'b1;
                n_cnt         = 6'd0;
                n_state       = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sq_step = 1'b1;
                n_cnt         = r_cnt + 6'd1;
                if (r_cnt == 6'(ttg_pkg::SQ_ITERS - 1)) begin
                    n_comp  = 2'd0;
                    n_state = S_DIV_INIT;
                end
            end
            S_DIV_INIT: begin
                o_cmd.dv_init = 1'b1;
                n_cnt         = 6'd0;
                n_state       = S_DIV;
            end
            S_DIV: begin
                o_cmd.dv_step = 1'b1;
                n_cnt         = r_cnt + 6'd1;
                if (r_cnt == 6'(ttg_pkg::Q_W - 1)) begin
                    n_state = S_DIV_STORE;
                end
            end
            S_DIV_STORE: begin
                o_cmd.dv_store = 1'b1;
                if (r_comp == 2'd2) begin
                    n_state = S_LOAD;
                end else begin
                    n_comp  = r_comp + 2'd1;
                    n_state = S_DIV_INIT;
                end
            end
            S_LOAD: begin
                if (!r_ovalid || i_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= 6'd0;
            r_comp   <= 2'd0;
            r_phase  <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_comp   <= n_comp;
            r_phase  <= n_phase;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

>>> design/ttg_datapath.sv
// ----------------------------------------------------------------------------
// ttg_datapath
// held vertices, block scaling, shared multiplier, square root and divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttg_datapath #(
    parameter int COORD_WIDTH = ttg_pkg::COORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ttg_pkg::t_cmd         i_cmd,
    output ttg_pkg::t_stat        o_stat,
    input  logic signed [31:0]   i_pos_x,
    input  logic signed [31:0]   i_pos_y,
    input  logic signed [31:0]   i_pos_z,
    input  logic signed [31:0]   i_tex_u,
    input  logic signed [31:0]   i_tex_v,
    output logic signed [15:0]   o_tangent_x,
    output logic signed [15:0]   o_tangent_y,
    output logic signed [15:0]   o_tangent_z,
    output logic                 o_mirrored
);

    localparam int CW    = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
    localparam int ED_W  = ttg_pkg::ED_W;
    localparam int OP_W  = ttg_pkg::OP_W;
    localparam int ACC_W = ttg_pkg::ACC_W;
    localparam int LEN_W = ttg_pkg::LEN_W;
    localparam int SQ_W  = ttg_pkg::SQ_W;
    localparam int Q_W   = ttg_pkg::Q_W;
    localparam int NUM_W = ttg_pkg::NUM_W;
    localparam int MAG_W = ttg_pkg::MAG_W;
    localparam int TAN_W = ttg_pkg::TAN_W;
    localparam int TB_SPLIT = ttg_pkg::TB_SPLIT;

    function automatic logic signed [ED_W-1:0] ext(input logic signed [CW-1:0] v);
        return ED_W'(v);
    endfunction

    logic signed [CW-1:0]    r_pos [2][3];
    logic signed [CW-1:0]    r_tex [2][2];
    logic signed [ED_W-1:0]  r_e [6];
    logic signed [ED_W-1:0]  r_d [4];
    logic signed [ACC_W-1:0] r_acc [ttg_pkg::ACC_N];
    logic signed [ACC_W-1:0] r_prod;
    ttg_pkg::t_mstep          r_mstep;
    logic                    r_mwb;
    logic [SQ_W-1:0]         r_sq_rem, r_sq_root, r_sq_bit;
    logic [LEN_W-1:0]        r_rem;
    logic [Q_W-1:0]          r_lo, r_q;
    logic signed [TAN_W-1:0] r_tan [3];
    logic signed [TAN_W-1:0] r_out_x, r_out_y, r_out_z;
    logic                    r_out_mir;

    logic signed [CW-1:0]      w_p [3];
    logic signed [CW-1:0]      w_u, w_v;
    logic                      w_e_big, w_e_mid, w_e_nz, w_e_down, w_e_up;
    logic                      w_d_big, w_d_mid, w_d_nz, w_d_down, w_d_up;
    logic                      w_g_big [3], w_g_mid [3], w_g_nz [3];
    logic                      w_g_down [3], w_g_up [3];
    logic signed [OP_W-1:0]    w_src [32];
    ttg_pkg::t_mstep            w_step;
    logic signed [OP_W-1:0]    w_opa, w_opb;
    logic signed [2*OP_W-1:0]  w_full;
    logic signed [ACC_W-1:0]   w_p64, w_add, w_base;
    logic [SQ_W-1:0]           w_sq_try;
    logic [LEN_W-1:0]          w_len;
    logic signed [ACC_W-1:0]   w_tc, w_tabs;
    logic [MAG_W-1:0]          w_tmag;
    logic [NUM_W-1:0]          w_num;
    logic [LEN_W:0]            w_rem2;
    logic [Q_W-1:0]            w_sat;
    logic                      w_mir, w_neg;
    logic signed [TAN_W-1:0]   w_c;

    assign w_p[0] = i_pos_x[CW-1:0];
    assign w_p[1] = i_pos_y[CW-1:0];
    assign w_p[2] = i_pos_z[CW-1:0];
    assign w_u    = i_tex_u[CW-1:0];
    assign w_v    = i_tex_v[CW-1:0];

    // group scaling status
    always_comb begin
        w_e_big = 1'b0;
        w_e_mid = 1'b0;
        w_e_nz  = 1'b0;
        for (int i = 0; i < 6; i++) begin
            w_e_big = w_e_big | ttg_pkg::mag_ge(ACC_W'(r_e[i]), ttg_pkg::FIT_K_IN);
            w_e_mid = w_e_mid | ttg_pkg::mag_ge(ACC_W'(r_e[i]), ttg_pkg::FIT_K_IN - 1);
            w_e_nz  = w_e_nz | (r_e[i] != '0);
        end
        w_d_big = 1'b0;
        w_d_mid = 1'b0;
        w_d_nz  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            w_d_big = w_d_big | ttg_pkg::mag_ge(ACC_W'(r_d[i]), ttg_pkg::FIT_K_IN);
            w_d_mid = w_d_mid | ttg_pkg::mag_ge(ACC_W'(r_d[i]), ttg_pkg::FIT_K_IN - 1);
            w_d_nz  = w_d_nz | (r_d[i] != '0);
        end
        w_e_down = w_e_big;
        w_e_up   = !w_e_big && w_e_nz && !w_e_mid;
        w_d_down = w_d_big;
        w_d_up   = !w_d_big && w_d_nz && !w_d_mid;
        for (int g = 0; g < 3; g++) begin
            w_g_big[g] = 1'b0;
            w_g_mid[g] = 1'b0;
            w_g_nz[g]  = 1'b0;
            for (int i = 0; i < 3; i++) begin
                w_g_big[g] = w_g_big[g] | ttg_pkg::mag_ge(r_acc[3*g+i], ttg_pkg::FIT_K_VEC);
                w_g_mid[g] = w_g_mid[g] | ttg_pkg::mag_ge(r_acc[3*g+i], ttg_pkg::FIT_K_VEC - 1);
                w_g_nz[g]  = w_g_nz[g] | (r_acc[3*g+i] != '0);
            end
            w_g_down[g] = w_g_big[g];
            w_g_up[g]   = !w_g_big[g] && w_g_nz[g] && !w_g_mid[g];
        end
        o_stat.ed_done  = !w_e_down && !w_e_up && !w_d_down && !w_d_up;
        o_stat.tbn_done = !w_g_down[0] && !w_g_up[0] && !w_g_down[1] && !w_g_up[1]
                          && !w_g_down[2] && !w_g_up[2];
    end

    // multiplier operand sources
    always_comb begin
        for (int k = 0; k < 32; k++) begin
            w_src[k] = '0;
        end
        for (int i = 0; i < 6; i++) begin
            w_src[ttg_pkg::SRC_E + i] = r_e[i][OP_W-1:0];
        end
        for (int i = 0; i < 4; i++) begin
            w_src[ttg_pkg::SRC_D + i] = r_d[i][OP_W-1:0];
        end
        for (int i = 0; i < 3; i++) begin
            w_src[ttg_pkg::SRC_NA + i]   = OP_W'(-r_e[i]);
            w_src[ttg_pkg::SRC_NB + i]   = OP_W'(r_e[3+i] - r_e[i]);
            w_src[ttg_pkg::SRC_T + i]    = r_acc[ttg_pkg::ACC_T + i][OP_W-1:0];
            w_src[ttg_pkg::SRC_B + i]    = r_acc[ttg_pkg::ACC_B + i][OP_W-1:0];
            w_src[ttg_pkg::SRC_N + i]    = r_acc[ttg_pkg::ACC_N0 + i][OP_W-1:0];
            w_src[ttg_pkg::SRC_TBLO + i] = {{(OP_W-TB_SPLIT){1'b0}},
                                            r_acc[ttg_pkg::ACC_TB + i][TB_SPLIT-1:0]};
            w_src[ttg_pkg::SRC_TBHI + i] = OP_W'(r_acc[ttg_pkg::ACC_TB + i] >>> TB_SPLIT);
        end
    end

    assign w_step = ttg_pkg::step_cmd(i_cmd.step);
    assign w_opa  = w_src[w_step.src_a];
    assign w_opb  = w_src[w_step.src_b];
    assign w_full = w_opa * w_opb;

    assign w_p64  = r_mstep.sh ? (r_prod <<< TB_SPLIT) : r_prod;
    assign w_add  = r_mstep.neg ? -w_p64 : w_p64;
    assign w_base = r_mstep.first ? '0 : r_acc[r_mstep.dst];

    assign w_sq_try = r_sq_root + r_sq_bit;
    assign w_len    = r_sq_root[LEN_W-1:0];

    always_comb begin
        case (i_cmd.comp)
            2'd0:    w_tc = r_acc[ttg_pkg::ACC_T];
            2'd1:    w_tc = r_acc[ttg_pkg::ACC_T + 4'd1];
            2'd2:    w_tc = r_acc[ttg_pkg::ACC_T + 4'd2];
            default: w_tc = '0;
        endcase
    end

    assign w_tabs = (w_tc < 0) ? -w_tc : w_tc;
    assign w_tmag = w_tabs[MAG_W-1:0];
    assign w_num  = {w_tmag, {ttg_pkg::UNIT_SH{1'b0}}} + NUM_W'(w_len >> 1);
    assign w_rem2 = {r_rem, r_lo[Q_W-1]};
    assign w_sat  = (r_q > ttg_pkg::UNIT_Q) ? ttg_pkg::UNIT_Q : r_q;
    assign w_mir  = r_acc[ttg_pkg::ACC_DOT][ACC_W-1];
    assign w_neg  = w_tc[ACC_W-1] ^ w_mir;
    assign w_c    = (w_len == '0) ? '0 : (w_neg ? -signed'(w_sat) : signed'(w_sat));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mwb <= 1'b0;
        end else begin
            r_mwb <= i_cmd.mul_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_slot_en) begin
            for (int i = 0; i < 3; i++) begin
                r_pos[i_cmd.load_slot][i] <= w_p[i];
            end
            r_tex[i_cmd.load_slot][0] <= w_u;
            r_tex[i_cmd.load_slot][1] <= w_v;
        end
        if (i_cmd.load_tri) begin
            for (int i = 0; i < 3; i++) begin
                r_e[i]   <= ext(r_pos[0][i]) - ext(r_pos[1][i]);
                r_e[3+i] <= ext(w_p[i]) - ext(r_pos[1][i]);
            end
            r_d[0] <= ext(r_tex[0][0]) - ext(r_tex[1][0]);
            r_d[1] <= ext(w_u) - ext(r_tex[1][0]);
            r_d[2] <= ext(r_tex[0][1]) - ext(r_tex[1][1]);
            r_d[3] <= ext(w_v) - ext(r_tex[1][1]);
        end
        if (i_cmd.fit_ed) begin
            for (int i = 0; i < 6; i++) begin
                if (w_e_down) begin
                    r_e[i] <= r_e[i] >>> 1;
                end else if (w_e_up) begin
                    r_e[i] <= r_e[i] <<< 1;
                end
            end
            for (int i = 0; i < 4; i++) begin
                if (w_d_down) begin
                    r_d[i] <= r_d[i] >>> 1;
                end else if (w_d_up) begin
                    r_d[i] <= r_d[i] <<< 1;
                end
            end
        end
        if (i_cmd.fit_tbn) begin
            for (int g = 0; g < 3; g++) begin
                for (int i = 0; i < 3; i++) begin
                    if (w_g_down[g]) begin
                        r_acc[3*g+i] <= r_acc[3*g+i] >>> 1;
                    end else if (w_g_up[g]) begin
                        r_acc[3*g+i] <= r_acc[3*g+i] <<< 1;
                    end
                end
            end
        end
        if (i_cmd.mul_issue) begin
            r_prod  <= w_full[ACC_W-1:0];
            r_mstep <= w_step;
        end
        if (r_mwb) begin
            r_acc[r_mstep.dst] <= w_base + w_add;
        end
        if (i_cmd.sq_init) begin
            r_sq_rem  <= r_acc[ttg_pkg::ACC_S][SQ_W-1:0];
            r_sq_root <= '0;
            r_sq_bit  <= SQ_W'(1) << (2 * (ttg_pkg::SQ_ITERS - 1));
        end
        if (i_cmd.sq_step) begin
            if (r_sq_rem >= w_sq_try) begin
                r_sq_rem  <= r_sq_rem - w_sq_try;
                r_sq_root <= (r_sq_root >> 1) + r_sq_bit;
            end else begin
                r_sq_root <= r_sq_root >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
        end
        if (i_cmd.dv_init) begin
            r_rem <= LEN_W'(w_num[NUM_W-1:Q_W]);
            r_lo  <= w_num[Q_W-1:0];
            r_q   <= '0;
        end
        if (i_cmd.dv_step) begin
            if (w_rem2 >= {1'b0, w_len}) begin
                r_rem <= LEN_W'(w_rem2 - {1'b0, w_len});
                r_q   <= {r_q[Q_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem2[LEN_W-1:0];
                r_q   <= {r_q[Q_W-2:0], 1'b0};
            end
            r_lo <= r_lo << 1;
        end
        if (i_cmd.dv_store) begin
            case (i_cmd.comp)
                2'd0:    r_tan[0] <= w_c;
                2'd1:    r_tan[1] <= w_c;
                2'd2:    r_tan[2] <= w_c;
                default: r_tan[0] <= r_tan[0];
            endcase
        end
        if (i_cmd.load_out) begin
            r_out_x   <= r_tan[0];
            r_out_y   <= r_tan[1];
            r_out_z   <= r_tan[2];
            r_out_mir <= w_mir;
        end
    end

    assign o_tangent_x = r_out_x;
    assign o_tangent_y = r_out_y;
    assign o_tangent_z = r_out_z;
    assign o_mirrored  = r_out_mir;

endmodule

>>> tb/sv/tb_triangle_tangent_generator.sv
// ----------------------------------------------------------------------------
// tb_triangle_tangent_generator
// drives vertex words under random bursts and output stalls, predicts each
// triangle's unit tangent and handedness, and compares every result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class tangent_scoreboard;
    typedef struct packed {
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [15:0] tz;
        logic               mir;
    } t_tangent;

    longint   held_pos[6];
    longint   held_tex[4];
    int       phase;
    t_tangent pending[$];
    int       mismatches;
    int       unexpected;
    int       checked;
    int       mirrored_seen;
    int       zero_seen;

    function new();
        phase = 0;
        mismatches = 0;
        unexpected = 0;
        checked = 0;
        mirrored_seen = 0;
        zero_seen = 0;
        foreach (held_pos[i]) held_pos[i] = 0;
        foreach (held_tex[i]) held_tex[i] = 0;
    endfunction

    function longint unsigned magn(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function longint unsigned gmax(longint v[6], int n);
        longint unsigned mx;
        mx = 0;
        for (int i = 0; i < n; i++) if (magn(v[i]) > mx) mx = magn(v[i]);
        return mx;
    endfunction

    function void scale_group(inout longint v[6], input int n, input int k);
        longint unsigned hi;
        longint unsigned lo;
        hi = 64'd1 << k;
        lo = 64'd1 << (k - 1);
        while (gmax(v, n) >= hi)
            for (int i = 0; i < n; i++) v[i] = v[i] >>> 1;
        while (gmax(v, n) != 0 && gmax(v, n) < lo)
            for (int i = 0; i < n; i++) v[i] = v[i] * 2;
    endfunction

    function longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function void note_vertex(logic signed [31:0] px, logic signed [31:0] py,
                              logic signed [31:0] pz, logic signed [31:0] tu,
                              logic signed [31:0] tv, logic ms);
        longint   p[3];
        longint   e[6];
        longint   d[6];
        longint   t[6];
        longint   b[6];
        longint   n[6];
        longint   na[3];
        longint   nb[3];
        longint   tb[3];
        longint   dot;
        longint unsigned s;
        longint unsigned len;
        longint unsigned q;
        longint   c;
        t_tangent r;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        if (ms) phase = 0;
        if (phase < 2) begin
            for (int i = 0; i < 3; i++) held_pos[phase * 3 + i] = p[i];
            held_tex[phase * 2] = tu;
            held_tex[phase * 2 + 1] = tv;
            phase++;
            return;
        end
        phase = 0;
        foreach (d[i]) begin
            d[i] = 0;
            t[i] = 0;
            b[i] = 0;
            n[i] = 0;
        end
        for (int i = 0; i < 3; i++) begin
            e[i] = held_pos[i] - held_pos[3 + i];
            e[3 + i] = p[i] - held_pos[3 + i];
        end
        d[0] = held_tex[0] - held_tex[2];
        d[1] = longint'(tu) - held_tex[2];
        d[2] = held_tex[1] - held_tex[3];
        d[3] = longint'(tv) - held_tex[3];
        scale_group(e, 6, 30);
        scale_group(d, 4, 30);
        for (int i = 0; i < 3; i++) begin
            t[i] = e[i] * d[3] - e[3 + i] * d[2];
            b[i] = e[i] * d[1] - e[3 + i] * d[0];
            na[i] = -e[i];
            nb[i] = e[3 + i] - e[i];
        end
        n[0] = na[1] * nb[2] - na[2] * nb[1];
        n[1] = na[2] * nb[0] - na[0] * nb[2];
        n[2] = na[0] * nb[1] - na[1] * nb[0];
        scale_group(t, 3, 20);
        scale_group(b, 3, 20);
        scale_group(n, 3, 20);
        tb[0] = t[1] * b[2] - t[2] * b[1];
        tb[1] = t[2] * b[0] - t[0] * b[2];
        tb[2] = t[0] * b[1] - t[1] * b[0];
        dot = tb[0] * n[0] + tb[1] * n[1] + tb[2] * n[2];
        r.mir = (dot < 0);
        s = t[0] * t[0] + t[1] * t[1] + t[2] * t[2];
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            c = 0;
            if (len != 0) begin
                q = (64'd16384 * magn(t[i]) + (len >> 1)) / len;
                if (q > 16384) q = 16384;
                c = q;
                if (t[i] < 0) c = -c;
                if (r.mir) c = -c;
            end
            if (i == 0) r.tx = c[15:0];
            else if (i == 1) r.ty = c[15:0];
            else r.tz = c[15:0];
        end
        if (r.mir) mirrored_seen++;
        if (len == 0) zero_seen++;
        pending.push_back(r);
    endfunction

    function void check_tangent(logic signed [15:0] tx, logic signed [15:0] ty,
                                logic signed [15:0] tz, logic mir);
        t_tangent x;
        if (pending.size() == 0) begin
            unexpected++;
            $display("unexpected result word: %0d %0d %0d mirrored=%0b", tx, ty, tz, mir);
            return;
        end
        x = pending.pop_front();
        checked++;
        if (x.tx !== tx || x.ty !== ty || x.tz !== tz || x.mir !== mir) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %0d %0d %0d mirrored=%0b, got %0d %0d %0d mirrored=%0b",
                         x.tx, x.ty, x.tz, x.mir, tx, ty, tz, mir);
        end
    endfunction
endclass

module tb_triangle_tangent_generator;
    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [31:0] i_pos_x;
    logic signed [31:0] i_pos_y;
    logic signed [31:0] i_pos_z;
    logic signed [31:0] i_tex_u;
    logic signed [31:0] i_tex_v;
    logic               i_mesh_start;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_tangent_x;
    logic signed [15:0] o_tangent_y;
    logic signed [15:0] o_tangent_z;
    logic               o_mirrored;

    tangent_scoreboard sb;
    int  sent;
    int  burst_left;
    bit  hold_req;

    triangle_tangent_generator u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_tex_u      (i_tex_u),
        .i_tex_v      (i_tex_v),
        .i_mesh_start (i_mesh_start),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_tangent_x  (o_tangent_x),
        .o_tangent_y  (o_tangent_y),
        .o_tangent_z  (o_tangent_z),
        .o_mirrored   (o_mirrored)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    initial begin
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        i_tex_u = '0;
        i_tex_v = '0;
        i_mesh_start = 1'b0;
        i_rst_n = 1'b0;
    end

    // vertex word: called at a falling edge, returns at the falling edge after acceptance or after a random idle gap
    task automatic send_vertex(input logic signed [31:0] px, input logic signed [31:0] py,
                               input logic signed [31:0] pz, input logic signed [31:0] tu,
                               input logic signed [31:0] tv, input logic ms);
        int gap;
        i_valid <= 1'b1;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        i_tex_u <= tu;
        i_tex_v <= tv;
        i_mesh_start <= ms;
        do @(posedge i_clk); while (!o_ready);
        sb.note_vertex(px, py, pz, tu, tv, ms);
        sent++;
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: rand_coord = $urandom;
            1: rand_coord = $signed($urandom_range(0, 2000)) - 1000;
            2: rand_coord = ($signed($urandom_range(0, 200)) - 100) <<< 16;
            default: rand_coord = $signed($urandom_range(0, 65536)) - 32768;
        endcase
    endfunction

    task automatic send_random(input int mode, input logic ms);
        send_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                    rand_coord(mode), rand_coord(mode), ms);
    endtask

    // receiver: changing stall pattern plus an on-request long hold
    initial begin
        int pat;
        int cyc;
        pat = 0;
        cyc = 0;
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_req = 1'b0;
            end
            cyc++;
            if (cyc % 97 == 0) pat = $urandom_range(0, 3);
            case (pat)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 1) == 1);
                2: i_ready <= ($urandom_range(0, 7) == 0);
                default: i_ready <= ((cyc % 5) != 0);
            endcase
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_tangent(o_tangent_x, o_tangent_y, o_tangent_z, o_mirrored);
    end

    initial begin
        #40_000_000;
        $display("timeout after %0d vertex words", sent);
        $display("triangle_tangent_generator verification failed");
        $finish;
    end

    initial begin
        int mode;
        sb = new();
        sent = 0;
        burst_left = 0;
        hold_req = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // plain triangle
        send_vertex(0, 0, 0, 0, 0, 1'b1);
        send_vertex(32'sh10000, 0, 0, 32'sh10000, 0, 1'b0);
        send_vertex(0, 32'sh10000, 0, 0, 32'sh10000, 1'b0);
        // mirrored uv mapping
        send_vertex(0, 0, 0, 0, 0, 1'b0);
        send_vertex(32'sh10000, 0, 0, 32'sh10000, 0, 1'b0);
        send_vertex(0, 32'sh10000, 0, 0, -32'sh10000, 1'b0);
        // identical texcoords, zero tangent
        send_vertex(5, 7, 9, 100, 100, 1'b0);
        send_vertex(-3, 2, 8, 100, 100, 1'b0);
        send_vertex(11, -4, 1, 100, 100, 1'b0);
        // all positions equal, zero normal
        send_vertex(42, 42, 42, 1, 2, 1'b0);
        send_vertex(42, 42, 42, 3, -5, 1'b0);
        send_vertex(42, 42, 42, -7, 9, 1'b0);
        // extremes of the coordinate range
        send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
        send_vertex(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b0);
        send_vertex(-1, 32'sh7fffffff, 0, 0, -1, 1'b0);
        // mesh start in the middle of a triangle
        send_vertex(1, 2, 3, 4, 5, 1'b0);
        send_vertex(9, 8, 7, 6, 5, 1'b1);
        send_vertex(-9, 3, 3, -6, 2, 1'b0);
        send_vertex(4, -8, 1, 7, -3, 1'b0);
        send_vertex(32'shffffffff, 32'sh0, 32'sh7fffffff, 32'sh1, 32'sh80000000, 1'b0);

        while (sent < 1250) begin
            if (sent > 400 && sent < 404) hold_req = 1'b1;
            if (sent > 800 && sent < 804) begin
                i_valid <= 1'b0;
                do @(negedge i_clk); while (sb.pending.size() != 0);
            end
            mode = $urandom_range(0, 3);
            if ($urandom_range(0, 4) != 0) begin
                send_random(mode, ($urandom_range(0, 3) == 0));
                send_random(mode, 1'b0);
                send_random(mode, 1'b0);
            end else begin
                send_random(mode, $urandom_range(0, 1));
            end
        end
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);

        $display("sent %0d vertex words, checked %0d tangent words", sent, sb.checked);
        $display("%0d mirrored and %0d zero-length tangents seen", sb.mirrored_seen,
                 sb.zero_seen);
        if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending.size() == 0) begin
            $display("triangle_tangent_generator verification clean");
        end else begin
            $display("%0d mismatches, %0d unexpected, %0d missing", sb.mismatches,
                     sb.unexpected, sb.pending.size());
            $display("triangle_tangent_generator verification failed");
        end
        $finish;
    end
endmodule
